// File: hdl/byte_level_token_text_decoder_core_assert.svh
// assertion helpers shared by the decoder modules
// each expects clk and rst_n in scope
`ifndef BYTE_LEVEL_TOKEN_TEXT_DECODER_CORE_ASSERT_SVH
`define BYTE_LEVEL_TOKEN_TEXT_DECODER_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define BLTD_ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("bltd assertion failed");

// consequence holds in the same cycle as the cause
`define BLTD_ASSERT_SAME(name, cause, effect) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error("bltd assertion failed");

// consequence holds in the cycle after the cause
`define BLTD_ASSERT_NEXT(name, cause, effect) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("bltd assertion failed");

`endif

// File: hdl/bltd_pkg.sv
package bltd_pkg;

    // output queue sizing: a burst is at most four bytes
    localparam int FIFO_DEPTH   = 16;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int MAX_BURST    = 4;
    // input accepted only while this many entries or fewer are queued
    localparam int ACCEPT_LEVEL = FIFO_DEPTH - 2 * MAX_BURST;

    // utf-8 lead byte classes
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] MASK2       = 8'hE0;
    localparam logic [7:0] LEAD2       = 8'hC0;
    localparam logic [7:0] MASK3       = 8'hF0;
    localparam logic [7:0] LEAD3       = 8'hE0;
    localparam logic [7:0] MASK4       = 8'hF8;
    localparam logic [7:0] LEAD4       = 8'hF0;

    // inverse byte map ranges
    localparam logic [20:0] PRINT_A_LO = 21'd33;
    localparam logic [20:0] PRINT_A_HI = 21'd126;
    localparam logic [20:0] PRINT_B_LO = 21'd161;
    localparam logic [20:0] PRINT_B_HI = 21'd172;
    localparam logic [20:0] PRINT_C_LO = 21'd174;
    localparam logic [20:0] PRINT_C_HI = 21'd255;
    localparam logic [20:0] SHIFT_BASE = 21'd256;
    localparam logic [20:0] SHIFT_LAST = 21'd323;
    localparam logic [6:0]  SHIFT_RUN1 = 7'd33;
    localparam logic [6:0]  SHIFT_RUN2 = 7'd67;
    localparam logic [7:0]  SHIFT_OFS2 = 8'd94;
    localparam logic [7:0]  SOFT_HYPHEN = 8'd173;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_token_end;
        logic       last_of_run;
    } out_item_t;

    // burst of decoded bytes from the parser into the output queue
    typedef struct packed {
        logic [2:0]                     count;
        out_item_t [MAX_BURST-1:0]      items;
    } push_t;

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] n;
        if (b < ASCII_LIMIT)
            n = 3'd1;
        else if ((b & MASK2) == LEAD2)
            n = 3'd2;
        else if ((b & MASK3) == LEAD3)
            n = 3'd3;
        else if ((b & MASK4) == LEAD4)
            n = 3'd4;
        else
            n = 3'd1;
        return n;
    endfunction

    // no check of continuation bytes
    function automatic logic [20:0] decode_cp(input logic [7:0] b0, input logic [7:0] b1,
                                               input logic [7:0] b2, input logic [7:0] b3,
                                               input logic [2:0] need);
        logic [20:0] cp;
        unique case (need)
            3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
            3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: cp = '0;
        endcase
        return cp;
    endfunction

    // bit 8 set when the codepoint has an inverse, byte in bits 7:0
    function automatic logic [8:0] inv_map(input logic [20:0] cp);
        logic [8:0] r;
        logic [6:0] n;
        n = 7'(cp - SHIFT_BASE);
        r = '0;
        if ((cp >= PRINT_A_LO && cp <= PRINT_A_HI) ||
            (cp >= PRINT_B_LO && cp <= PRINT_B_HI) ||
            (cp >= PRINT_C_LO && cp <= PRINT_C_HI))
            r = {1'b1, cp[7:0]};
        else if (cp >= SHIFT_BASE && cp <= SHIFT_LAST)
        begin
            if (n < SHIFT_RUN1)
                r = {1'b1, 1'b0, n};
            else if (n < SHIFT_RUN2)
                r = {1'b1, 8'({1'b0, n} + SHIFT_OFS2)};
            else
                r = {1'b1, SOFT_HYPHEN};
        end
        return r;
    endfunction

endpackage

// File: hdl/bltd_if.sv
// token text byte channel
interface bltd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       token_end;

    modport source (output valid, output text_byte, output token_end, input ready);
    modport sink (input valid, input text_byte, input token_end, output ready);
endinterface

// decoded raw byte channel
interface bltd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_token_end;
    logic       last_of_run;

    modport source (output valid, output out_byte, output out_token_end,
                    output last_of_run, input ready);
    modport sink (input valid, input out_byte, input out_token_end,
                  input last_of_run, output ready);
endinterface

// File: hdl/byte_level_token_text_decoder_core.sv
// channel     | dir  | payload                                  | per transfer
// ------------+------+------------------------------------------+----------------------
// token_text  | in   | text_byte[7:0], token_end                | one vocabulary byte
// raw_text    | out  | out_byte[7:0], out_token_end, last_of_run | one decoded text byte
//
// one input byte per cycle while token_text.ready is high; each byte is registered in
// the input stage, its results land in the queue the cycle after, first one visible then
// an input byte yields zero to four bytes, bursts drain from a 16-entry queue
// rst_n clears the stage, the partial-sequence buffer and the queue pointers
// token_text.ready drops while more than 8 entries are queued, so a stall on
// raw_text backs up into token_text without losing or splitting a burst
module byte_level_token_text_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    bltd_in_if.sink     token_text,
    bltd_out_if.source  raw_text
);

    // burst of decoded bytes from the parse stage
    bltd_pkg::push_t               push;
    // queue occupancy, used for input flow control
    logic [bltd_pkg::FIFO_AW:0]    level;
    logic                          room;

    // room for the byte in the stage plus the one being offered, worst case
    assign room = level <= (bltd_pkg::FIFO_AW+1)'(bltd_pkg::ACCEPT_LEVEL);

    // input register, utf-8 reassembly and inverse byte map
    bltd_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .token_text (token_text),
        .room       (room),
        .push       (push)
    );

    // multi-write queue that parts the parser from the output handshake
    bltd_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .raw_text (raw_text),
        .level    (level)
    );

endmodule

// File: hdl/bltd_parse.sv
`include "byte_level_token_text_decoder_core_assert.svh"

module bltd_parse (
    input  logic           clk,
    input  logic           rst_n,
    bltd_in_if.sink        token_text,
    input  logic           room,
    output bltd_pkg::push_t push
);

    logic        take;
    logic        stage_valid_reg;
    logic [7:0]  stage_byte_reg;
    logic        stage_end_reg;

    logic [7:0]  pend_reg [0:2];
    logic [1:0]  pend_cnt_reg;
    logic [7:0]  pend_next [0:2];
    logic [1:0]  pend_cnt_next;

    logic [7:0]  ext [0:6];
    logic [2:0]  len;
    logic [2:0]  need_at [0:3];
    logic        complete_at [0:3];
    logic [8:0]  map_at [0:3];

    logic [2:0]  pos;
    logic [2:0]  n;
    logic [2:0]  n_last;
    logic        stop;
    bltd_pkg::out_item_t [bltd_pkg::MAX_BURST-1:0] items;

    assign token_text.ready = room;
    assign take = token_text.valid && token_text.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            pend_cnt_reg    <= '0;
            for (int k = 0; k < 3; k++)
                pend_reg[k] <= '0;
        end
        else
        begin
            stage_valid_reg <= take;
            if (stage_valid_reg)
            begin
                pend_cnt_reg <= pend_cnt_next;
                for (int k = 0; k < 3; k++)
                    pend_reg[k] <= pend_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_byte_reg <= token_text.text_byte;
            stage_end_reg  <= token_text.token_end;
        end
    end

    // buffered bytes followed by the new byte, zero padded
    always_comb
    begin
        len = {1'b0, pend_cnt_reg} + 3'd1;
        for (int k = 0; k < 7; k++)
        begin
            if (k < 3 && 3'(k) < {1'b0, pend_cnt_reg})
                ext[k] = pend_reg[k < 3 ? k : 0];
            else if (3'(k) == {1'b0, pend_cnt_reg})
                ext[k] = stage_byte_reg;
            else
                ext[k] = '0;
        end
    end

    // per start position: sequence length, whether it fits, mapped byte
    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            need_at[p]     = bltd_pkg::seq_len(ext[p]);
            complete_at[p] = (3'(p) + need_at[p]) <= len;
            map_at[p]      = bltd_pkg::inv_map(bltd_pkg::decode_cp(ext[p], ext[p+1],
                                                                    ext[p+2], ext[p+3],
                                                                    need_at[p]));
        end
    end

    // walk the sequences left to right
    always_comb
    begin
        pos           = '0;
        n             = '0;
        stop          = 1'b0;
        items         = '0;
        pend_cnt_next = '0;
        for (int k = 0; k < 3; k++)
            pend_next[k] = pend_reg[k];
        for (int step = 0; step < 4; step++)
        begin
            if (!stop && pos < len)
            begin
                if (need_at[pos[1:0]] > 3'd1 && complete_at[pos[1:0]])
                begin
                    if (map_at[pos[1:0]][8])
                    begin
                        items[n[1:0]].out_byte = map_at[pos[1:0]][7:0];
                        n = n + 3'd1;
                    end
                    else
                    begin
                        // unmapped codepoint: raw bytes of the sequence
                        for (int j = 0; j < 4; j++)
                        begin
                            if (3'(j) < need_at[pos[1:0]])
                            begin
                                items[n[1:0]].out_byte = ext[3'(pos + 3'(j))];
                                n = n + 3'd1;
                            end
                        end
                    end
                    pos = pos + need_at[pos[1:0]];
                end
                else if (need_at[pos[1:0]] > 3'd1 && !stage_end_reg)
                begin
                    // sequence still open: hold the rest
                    for (int k = 0; k < 3; k++)
                        pend_next[k] = ext[3'(pos + 3'(k))];
                    pend_cnt_next = 2'(len - pos);
                    stop = 1'b1;
                end
                else
                begin
                    // single byte, or lead byte cut off by token end
                    items[n[1:0]].out_byte = ext[pos];
                    n   = n + 3'd1;
                    pos = pos + 3'd1;
                end
            end
        end
        n_last = n - 3'd1;
        if (n != 3'd0)
        begin
            items[n_last[1:0]].last_of_run   = 1'b1;
            items[n_last[1:0]].out_token_end = stage_end_reg;
        end
        push.items = items;
        push.count = stage_valid_reg ? n : 3'd0;
    end

    `BLTD_ASSERT_SAME(a_end_gives_output, stage_valid_reg && stage_end_reg, push.count != 3'd0)
    `BLTD_ASSERT_NEXT(a_end_clears_pending, stage_valid_reg && stage_end_reg, pend_cnt_reg == 2'd0)
    `BLTD_ASSERT_SAME(a_idle_no_push, !stage_valid_reg, push.count == 3'd0)

endmodule

// File: hdl/bltd_out_fifo.sv
`include "byte_level_token_text_decoder_core_assert.svh"

module bltd_out_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bltd_pkg::push_t               push,
    bltd_out_if.source                    raw_text,
    output logic [bltd_pkg::FIFO_AW:0]    level
);

    bltd_pkg::out_item_t mem_reg [0:bltd_pkg::FIFO_DEPTH-1];
    logic [bltd_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [bltd_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [bltd_pkg::FIFO_AW:0]   level_reg;
    logic [bltd_pkg::FIFO_AW:0]   level_next;
    logic                         pop;
    // occupancy plus the incoming burst, before any pop
    logic [bltd_pkg::FIFO_AW+1:0] fill_sum;

    assign pop        = raw_text.valid && raw_text.ready;
    assign level_next = level_reg + (bltd_pkg::FIFO_AW+1)'(push.count)
                        - (bltd_pkg::FIFO_AW+1)'(pop);
    assign level      = level_reg;
    assign fill_sum   = {1'b0, level_reg} + (bltd_pkg::FIFO_AW+2)'(push.count);

    assign raw_text.valid         = level_reg != '0;
    assign raw_text.out_byte      = mem_reg[rd_ptr_reg].out_byte;
    assign raw_text.out_token_end = mem_reg[rd_ptr_reg].out_token_end;
    assign raw_text.last_of_run   = mem_reg[rd_ptr_reg].last_of_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + bltd_pkg::FIFO_AW'(push.count);
            rd_ptr_reg <= rd_ptr_reg + bltd_pkg::FIFO_AW'(pop);
            level_reg  <= level_next;
        end
    end

    // burst write at consecutive slots
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < bltd_pkg::MAX_BURST; k++)
        begin
            if (3'(k) < push.count)
                mem_reg[bltd_pkg::FIFO_AW'(wr_ptr_reg + bltd_pkg::FIFO_AW'(k))] <= push.items[k];
        end
    end

    `BLTD_ASSERT_ALWAYS(a_level_bound, level_reg <= (bltd_pkg::FIFO_AW+1)'(bltd_pkg::FIFO_DEPTH))
    `BLTD_ASSERT_SAME(a_no_overflow, push.count != 3'd0, fill_sum <= (bltd_pkg::FIFO_AW+2)'(bltd_pkg::FIFO_DEPTH))
    `BLTD_ASSERT_NEXT(a_out_held, raw_text.valid && !raw_text.ready, raw_text.valid)

endmodule
